// File: rtl/core/bra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bra_pkg
// shared constants of the bitmap run allocator: sequencer states,
// operation codes, register map and reset values
// ----------------------------------------------------------------------------
package bra_pkg;

  // operation codes carried by op_i
  localparam logic [2:0] OP_TEST  = 3'd0;
  localparam logic [2:0] OP_SET   = 3'd1;
  localparam logic [2:0] OP_CLEAR = 3'd2;
  localparam logic [2:0] OP_SCAN  = 3'd3;
  localparam logic [2:0] OP_WIPE  = 3'd4;

  // register map, one 32-bit register
  localparam logic REG_BYTES_IN_USE = 1'b0;

  // reset values
  localparam logic [7:0] BYTES_IN_USE_RST = 8'd128;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CLEAR = 5'b00010,
    ST_READ  = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_WIPE  = 5'b10000
  } state_e;

endpackage
`default_nettype wire

// File: rtl/core/bra_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bra_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module bra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire                                        clk_i,
  input  wire                                        we_i,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]                           wdata_i,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: rtl/core/bitmap_run_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_run_allocator
// bit-per-unit allocation map with test, set, clear, clear-all and a
// first-fit scan for a run of clear units
// ----------------------------------------------------------------------------
//  channel   | handshake               | payload
//  ----------+-------------------------+-------------------------------------
//  command   | start_i, busy_o         | op_i, bit_index_i, run_length_i
//  result    | done_o (one-cycle pulse)| bit_value_o, found_o, start_index_o
//  config    | psel/penable/pwrite     | paddr, pwdata, prdata (pready = 1)
//
//  test, set, clear: one ram read, then result and write-back
//  scan: the byte unit eats one map byte a cycle
//  from the ram read port, stopping at the first fit or the last byte in use
//  clear all: one byte written per cycle, then the strobe
//  after reset a clearing pass over the map runs with busy_o high
//  results are pulsed on done_o; the receiver cannot stall
// ----------------------------------------------------------------------------
module bitmap_run_allocator #(
  parameter int MAP_BYTES = 128
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // command
  input  wire         start_i,
  output logic        busy_o,
  input  wire  [2:0]  op_i,
  input  wire  [9:0]  bit_index_i,
  input  wire  [10:0] run_length_i,
  // result
  output logic        done_o,
  output logic        bit_value_o,
  output logic        found_o,
  output logic [9:0]  start_index_o,
  // configuration
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW       = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int MAP_BITS = MAP_BYTES * 8;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_BYTES - 1);

  bra_pkg::state_e state_q, state_d;

  logic [7:0]    biu_q;
  logic [AW-1:0] sw_q, sw_d;
  logic [7:0]    rd_q, rd_d;
  logic [7:0]    ev_q, ev_d;
  logic          rdv_q, rdv_d;
  logic [10:0]   run_q, run_d;
  logic [2:0]    op_q, op_d;
  logic [9:0]    idx_q, idx_d;
  logic [10:0]   want_q, want_d;
  logic [7:0]    nb_q, nb_d;
  logic          done_q, done_d;
  logic          bitv_q, bitv_d;
  logic          found_q, found_d;
  logic [9:0]    sidx_q, sidx_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic          cfg_wr;
  logic [7:0]    nb_now;
  logic          idx_ok;

  // byte unit results
  logic [10:0]   bu_run;
  logic          bu_hit;
  logic [2:0]    bu_pos;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == bra_pkg::REG_BYTES_IN_USE);
  assign prdata = (paddr[2] == bra_pkg::REG_BYTES_IN_USE) ? {24'd0, biu_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      biu_q <= bra_pkg::BYTES_IN_USE_RST;
    end else if (cfg_wr) begin
      biu_q <= pwdata[7:0];
    end
  end

  // bytes covered by scan, clamped to the map
  assign nb_now = (int'(biu_q) > MAP_BYTES) ? 8'(MAP_BYTES) : biu_q;
  assign idx_ok = int'(bit_index_i) < MAP_BITS;

  // map storage
  bra_ram #(
    .WIDTH (8),
    .DEPTH (MAP_BYTES)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // byte unit: walks eight units of one map byte
  always_comb begin
    logic [10:0] run;
    logic        hit;
    logic [2:0]  pos;
    run = run_q;
    hit = 1'b0;
    pos = 3'd0;
    for (int b = 0; b < 8; b++) begin
      if (!hit) begin
        if (ram_rdata[b]) begin
          run = 11'd0;
        end else begin
          run = run + 11'd1;
          if (run == want_q) begin
            hit = 1'b1;
            pos = 3'(b);
          end
        end
      end
    end
    bu_run = run;
    bu_hit = hit;
    bu_pos = pos;
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    sw_d      = sw_q;
    rd_d      = rd_q;
    ev_d      = ev_q;
    rdv_d     = 1'b0;
    run_d     = run_q;
    op_d      = op_q;
    idx_d     = idx_q;
    want_d    = want_q;
    nb_d      = nb_q;
    done_d    = 1'b0;
    bitv_d    = 1'b0;
    found_d   = 1'b0;
    sidx_d    = 10'd0;
    ram_we    = 1'b0;
    ram_waddr = sw_q;
    ram_wdata = 8'd0;
    ram_raddr = AW'(rd_q);
    case (state_q)
      bra_pkg::ST_CLEAR, bra_pkg::ST_WIPE: begin
        ram_we = 1'b1;
        if (sw_q == LAST_ADDR) begin
          sw_d    = '0;
          state_d = bra_pkg::ST_IDLE;
          done_d  = (state_q == bra_pkg::ST_WIPE);
        end else begin
          sw_d = sw_q + 1'b1;
        end
      end
      bra_pkg::ST_IDLE: begin
        ram_raddr = AW'(bit_index_i[9:3]);
        if (start_i) begin
          op_d   = op_i;
          idx_d  = bit_index_i;
          want_d = run_length_i;
          nb_d   = nb_now;
          case (op_i)
            bra_pkg::OP_TEST, bra_pkg::OP_SET, bra_pkg::OP_CLEAR: begin
              if (idx_ok) begin
                state_d = bra_pkg::ST_READ;
              end else begin
                done_d = 1'b1;
              end
            end
            bra_pkg::OP_SCAN: begin
              if (run_length_i == 11'd0 || run_length_i > {nb_now, 3'd0}) begin
                done_d = 1'b1;
              end else begin
                state_d = bra_pkg::ST_SCAN;
                rd_d    = 8'd0;
                run_d   = 11'd0;
              end
            end
            bra_pkg::OP_WIPE: begin
              sw_d    = '0;
              state_d = bra_pkg::ST_WIPE;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      bra_pkg::ST_READ: begin
        ram_waddr = AW'(idx_q[9:3]);
        done_d    = 1'b1;
        state_d   = bra_pkg::ST_IDLE;
        case (op_q)
          bra_pkg::OP_TEST: begin
            bitv_d = ram_rdata[idx_q[2:0]];
          end
          bra_pkg::OP_SET: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | (8'd1 << idx_q[2:0]);
          end
          bra_pkg::OP_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata & ~(8'd1 << idx_q[2:0]);
          end
          default: begin
            ram_we = 1'b0;
          end
        endcase
      end
      bra_pkg::ST_SCAN: begin
        // issue the next byte read while the previous one is evaluated
        if (rd_q < nb_q) begin
          rd_d  = rd_q + 8'd1;
          rdv_d = 1'b1;
          ev_d  = rd_q;
        end
        if (rdv_q) begin
          run_d = bu_run;
          if (bu_hit) begin
            done_d  = 1'b1;
            found_d = 1'b1;
            sidx_d  = {ev_q[6:0], bu_pos} + 10'd1 - want_q[9:0];
            state_d = bra_pkg::ST_IDLE;
            rdv_d   = 1'b0;
          end else if (ev_q == nb_q - 8'd1) begin
            done_d  = 1'b1;
            state_d = bra_pkg::ST_IDLE;
            rdv_d   = 1'b0;
          end
        end
      end
      default: begin
        state_d = bra_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bra_pkg::ST_CLEAR;
      sw_q    <= '0;
      rdv_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sw_q    <= sw_d;
      rdv_q   <= rdv_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_q    <= rd_d;
    ev_q    <= ev_d;
    run_q   <= run_d;
    op_q    <= op_d;
    idx_q   <= idx_d;
    want_q  <= want_d;
    nb_q    <= nb_d;
    bitv_q  <= bitv_d;
    found_q <= found_d;
    sidx_q  <= sidx_d;
  end

  // outputs, fields read zero outside the strobe
  assign busy_o        = (state_q != bra_pkg::ST_IDLE);
  assign done_o        = done_q;
  assign bit_value_o   = done_q & bitv_q;
  assign found_o       = done_q & found_q;
  assign start_index_o = done_q ? sidx_q : 10'd0;

endmodule
`default_nettype wire

// File: rtl/core/bra_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bra_checker
// port-level checks of the bitmap run allocator, bound to the top level
// ----------------------------------------------------------------------------
module bra_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        start_i,
  input wire        busy_o,
  input wire        done_o,
  input wire        bit_value_o,
  input wire        found_o,
  input wire [9:0]  start_index_o
);

  // a result transfer comes as the block goes idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // an accepted command either keeps the block busy or answers at once
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted command vanished");

  // no result without a command in flight
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !$past(busy_o)) |-> $past(start_i))
    else $error("result without command");

  // a test bit and a found run never come together
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(bit_value_o && found_o))
    else $error("test and scan result mixed");

  // a start index only with a found run
  a_start_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !found_o |-> (start_index_o == 10'd0))
    else $error("start index without found run");

endmodule

bind bitmap_run_allocator bra_checker u_bra_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .bit_value_o   (bit_value_o),
  .found_o       (found_o),
  .start_index_o (start_index_o)
);
`default_nettype wire
